FILE: sv/ckb_pkg.sv
// ----------------------------------------------------------------------------
// ckb_pkg
// Types, constants and register codes shared by the color-key sprite blitter.
// ----------------------------------------------------------------------------
package ckb_pkg;

  localparam int FRAME_SHORT = 320;
  localparam int FRAME_LONG  = 480;
  localparam int FRAME_CELLS = FRAME_SHORT * FRAME_LONG;
  localparam int ADDR_W      = $clog2(FRAME_CELLS);

  localparam int COORD_W     = 10;
  localparam int DIM_W       = $clog2(FRAME_LONG + 1) > $clog2(FRAME_SHORT + 1) ?
                               $clog2(FRAME_LONG + 1) : $clog2(FRAME_SHORT + 1);
  localparam int PROD_W      = COORD_W + DIM_W;
  localparam int RGB_W       = 24;
  localparam int POS_W       = 9;
  localparam int MODE_W      = 3;

  localparam logic [COORD_W-1:0] COORD_MAX = '1;
  localparam logic [DIM_W-1:0]   COLS_PORTRAIT  = DIM_W'(FRAME_SHORT);
  localparam logic [DIM_W-1:0]   ROWS_PORTRAIT  = DIM_W'(FRAME_LONG);
  localparam logic [DIM_W-1:0]   COLS_LANDSCAPE = DIM_W'(FRAME_LONG);
  localparam logic [DIM_W-1:0]   ROWS_LANDSCAPE = DIM_W'(FRAME_SHORT);
  localparam logic [ADDR_W-1:0]  LAST_CELL      = ADDR_W'(FRAME_CELLS - 1);

  // Mode bit positions.
  localparam int MODE_KEY     = 0;
  localparam int MODE_RECOLOR = 1;
  localparam int MODE_LAND    = 2;

  // Register map: index = paddr[4:2].
  localparam int PADDR_W   = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MODE_BITS     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_COLOR     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_RECOLOR_MATCH = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RECOLOR_VALUE = 3'd6;

  typedef struct packed {
    logic [RGB_W-1:0] pixel_color;
    logic             first_pixel;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [RGB_W-1:0]   shown_color;
    logic [RGB_W-1:0]   background_color;
    logic               in_frame;
  } out_t;

  typedef struct packed {
    logic [POS_W-1:0]  origin_x;
    logic [POS_W-1:0]  origin_y;
    logic [POS_W-1:0]  sprite_width;
    logic [MODE_W-1:0] mode_bits;
    logic [RGB_W-1:0]  key_color;
    logic [RGB_W-1:0]  recolor_match;
    logic [RGB_W-1:0]  recolor_value;
  } cfg_t;

  // Position of the pixel being accepted, as seen by the frame access.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               in_bounds;
    logic               landscape;
    logic [ADDR_W-1:0]  addr;
  } pos_t;

endpackage

FILE: sv/ckb_frame_mem.sv
// ----------------------------------------------------------------------------
// ckb_frame_mem
// One frame store: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module ckb_frame_mem (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [ckb_pkg::ADDR_W-1:0] wr_addr,
  input  logic [ckb_pkg::RGB_W-1:0]  wr_data,
  input  logic                      rd_en,
  input  logic [ckb_pkg::ADDR_W-1:0] rd_addr,
  output logic [ckb_pkg::RGB_W-1:0]  rd_data
);

  logic [ckb_pkg::RGB_W-1:0] mem_r [ckb_pkg::FRAME_CELLS];
  logic [ckb_pkg::RGB_W-1:0] rd_data_r;

  // A read and a write to the same entry in one cycle return the old value.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/ckb_cfg_regs.sv
// ----------------------------------------------------------------------------
// ckb_cfg_regs
// APB-style register file holding origin, width, mode and color settings.
// ----------------------------------------------------------------------------
module ckb_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output ckb_pkg::cfg_t               cfg
);

  ckb_pkg::cfg_t cfg_r;
  logic [ckb_pkg::REG_IDX_W-1:0] idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ckb_pkg::PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.sprite_width  <= ckb_pkg::POS_W'(1);
      cfg_r.mode_bits     <= '0;
      cfg_r.key_color     <= '0;
      cfg_r.recolor_match <= '0;
      cfg_r.recolor_value <= '0;
    end else if (wr_en) begin
      case (idx)
        ckb_pkg::REG_ORIGIN_X:      cfg_r.origin_x      <= pwdata[ckb_pkg::POS_W-1:0];
        ckb_pkg::REG_ORIGIN_Y:      cfg_r.origin_y      <= pwdata[ckb_pkg::POS_W-1:0];
        ckb_pkg::REG_SPRITE_WIDTH:  cfg_r.sprite_width  <= pwdata[ckb_pkg::POS_W-1:0];
        ckb_pkg::REG_MODE_BITS:     cfg_r.mode_bits     <= pwdata[ckb_pkg::MODE_W-1:0];
        ckb_pkg::REG_KEY_COLOR:     cfg_r.key_color     <= pwdata[ckb_pkg::RGB_W-1:0];
        ckb_pkg::REG_RECOLOR_MATCH: cfg_r.recolor_match <= pwdata[ckb_pkg::RGB_W-1:0];
        ckb_pkg::REG_RECOLOR_VALUE: cfg_r.recolor_value <= pwdata[ckb_pkg::RGB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ckb_pkg::REG_ORIGIN_X:      prdata = 32'(cfg_r.origin_x);
      ckb_pkg::REG_ORIGIN_Y:      prdata = 32'(cfg_r.origin_y);
      ckb_pkg::REG_SPRITE_WIDTH:  prdata = 32'(cfg_r.sprite_width);
      ckb_pkg::REG_MODE_BITS:     prdata = 32'(cfg_r.mode_bits);
      ckb_pkg::REG_KEY_COLOR:     prdata = 32'(cfg_r.key_color);
      ckb_pkg::REG_RECOLOR_MATCH: prdata = 32'(cfg_r.recolor_match);
      ckb_pkg::REG_RECOLOR_VALUE: prdata = 32'(cfg_r.recolor_value);
      default:                    prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/ckb_cursor.sv
// ----------------------------------------------------------------------------
// ckb_cursor
// Sprite cursor: places each accepted pixel, advances and wraps the cursor,
// and forms the frame address of the position.
// ----------------------------------------------------------------------------
module ckb_cursor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic          first_pixel,
  input  ckb_pkg::cfg_t cfg,
  output ckb_pkg::pos_t pos
);

  logic [ckb_pkg::COORD_W-1:0] cursor_x_r, cursor_x_nxt;
  logic [ckb_pkg::COORD_W-1:0] cursor_y_r, cursor_y_nxt;
  logic [ckb_pkg::COORD_W-1:0] x, y, width;
  logic [ckb_pkg::COORD_W:0]   next_x, limit;
  logic [ckb_pkg::DIM_W-1:0]   cols, rows;
  logic [ckb_pkg::PROD_W-1:0]  row_base, lin_addr;
  logic                        landscape;

  assign landscape = cfg.mode_bits[ckb_pkg::MODE_LAND];
  assign cols = landscape ? ckb_pkg::COLS_LANDSCAPE : ckb_pkg::COLS_PORTRAIT;
  assign rows = landscape ? ckb_pkg::ROWS_LANDSCAPE : ckb_pkg::ROWS_PORTRAIT;

  assign x = first_pixel ? ckb_pkg::COORD_W'(cfg.origin_x) : cursor_x_r;
  assign y = first_pixel ? ckb_pkg::COORD_W'(cfg.origin_y) : cursor_y_r;

  // A zero width wraps after every pixel, like a width of one.
  assign width  = (cfg.sprite_width == '0) ? ckb_pkg::COORD_W'(1)
                                           : ckb_pkg::COORD_W'(cfg.sprite_width);
  assign next_x = (ckb_pkg::COORD_W+1)'(x) + (ckb_pkg::COORD_W+1)'(1);
  assign limit  = (ckb_pkg::COORD_W+1)'(cfg.origin_x) + (ckb_pkg::COORD_W+1)'(width);

  // Multiply by the column count of the current orientation; only meaningful when in bounds.
  assign row_base = ckb_pkg::PROD_W'(y) * ckb_pkg::PROD_W'(cols);
  assign lin_addr = row_base + ckb_pkg::PROD_W'(x);

  always_comb begin
    if (next_x >= limit) begin
      cursor_x_nxt = ckb_pkg::COORD_W'(cfg.origin_x);
      cursor_y_nxt = (y < ckb_pkg::COORD_MAX) ? y + ckb_pkg::COORD_W'(1)
                                              : ckb_pkg::COORD_MAX;
    end else begin
      cursor_x_nxt = next_x[ckb_pkg::COORD_W-1:0];
      cursor_y_nxt = y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      cursor_y_r <= '0;
    end else if (accept) begin
      cursor_x_r <= cursor_x_nxt;
      cursor_y_r <= cursor_y_nxt;
    end
  end

  assign pos.x         = x;
  assign pos.y         = y;
  assign pos.in_bounds = ((ckb_pkg::DIM_W+1)'(x) < (ckb_pkg::DIM_W+1)'(cols)) &&
                         ((ckb_pkg::DIM_W+1)'(y) < (ckb_pkg::DIM_W+1)'(rows));
  assign pos.landscape = landscape;
  assign pos.addr      = lin_addr[ckb_pkg::ADDR_W-1:0];

endmodule

FILE: sv/color_key_sprite_blit.sv
// ----------------------------------------------------------------------------
// color_key_sprite_blit
// Color-key transparent sprite blit into a portrait or landscape frame store.
// ----------------------------------------------------------------------------
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+------------------------------------
//  in       | in_valid / in_stall     | in_data  (ckb_pkg::in_t)
//  out      | out_valid / out_stall   | out_data (ckb_pkg::out_t)
//  config   | psel penable pwrite     | paddr, pwdata, prdata, pready
//
// One pixel per cycle sustained while no clearing pass or stall holds the
// input; a result is registered in the modify stage at its transfer in,
// then in the output register. The frame read-modify-write (read at
// transfer, write as the pixel leaves the modify stage) sets the rate,
// with forwarding for back-to-back hits on one entry. After reset a clearing
// pass writes zero to every entry of both stores; in_stall is high
// meanwhile, and register writes are taken as usual. in_stall also rises
// when the modify stage is full and the output register is full and stalled.
// ----------------------------------------------------------------------------
module color_key_sprite_blit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ckb_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ckb_pkg::out_t               out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ckb_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ckb_pkg::cfg_t cfg;
  ckb_pkg::pos_t pos;
  logic          accept;

  // Clearing pass.
  logic                       clr_busy_r;
  logic [ckb_pkg::ADDR_W-1:0] clr_addr_r;

  // Modify stage.
  logic                       s1_valid_r, s1_valid_nxt;
  ckb_pkg::pos_t              s1_pos_r;
  logic [ckb_pkg::RGB_W-1:0]  s1_pix_r;
  logic                       s1_fwd_r;
  logic [ckb_pkg::RGB_W-1:0]  s1_fwd_data_r;
  logic                       s1_adv, s1_wr;
  logic [ckb_pkg::RGB_W-1:0]  rd_portrait, rd_landscape, back, shown, keyed;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  ckb_pkg::out_t              out_data_r;

  // Memory write port.
  logic                       wr_portrait, wr_landscape;
  logic [ckb_pkg::ADDR_W-1:0] wr_addr;
  logic [ckb_pkg::RGB_W-1:0]  wr_data;

  ckb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ckb_cursor u_cursor (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .first_pixel (in_data.first_pixel),
    .cfg         (cfg),
    .pos         (pos)
  );

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = clr_busy_r || (s1_valid_r && !s1_adv);
  assign accept   = in_valid && !in_stall;
  assign s1_wr    = s1_valid_r && s1_adv && s1_pos_r.in_bounds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + ckb_pkg::ADDR_W'(1);
      if (clr_addr_r == ckb_pkg::LAST_CELL) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_r) begin
      wr_portrait  = 1'b1;
      wr_landscape = 1'b1;
      wr_addr      = clr_addr_r;
      wr_data      = '0;
    end else begin
      wr_portrait  = s1_wr && !s1_pos_r.landscape;
      wr_landscape = s1_wr && s1_pos_r.landscape;
      wr_addr      = s1_pos_r.addr;
      wr_data      = shown;
    end
  end

  ckb_frame_mem u_portrait (
    .clk     (clk),
    .wr_en   (wr_portrait),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (pos.addr),
    .rd_data (rd_portrait)
  );

  ckb_frame_mem u_landscape (
    .clk     (clk),
    .wr_en   (wr_landscape),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (pos.addr),
    .rd_data (rd_landscape)
  );

  // The memory returns the old value when the pixel ahead writes the same
  // entry in the cycle of our read, so that value is forwarded instead.
  always_comb begin
    if (!s1_pos_r.in_bounds) begin
      back = '0;
    end else if (s1_fwd_r) begin
      back = s1_fwd_data_r;
    end else begin
      back = s1_pos_r.landscape ? rd_landscape : rd_portrait;
    end
    keyed = (cfg.mode_bits[ckb_pkg::MODE_KEY] && (s1_pix_r == cfg.key_color)) ?
            back : s1_pix_r;
    shown = (cfg.mode_bits[ckb_pkg::MODE_RECOLOR] && (keyed == cfg.recolor_match)) ?
            cfg.recolor_value : keyed;
  end

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_valid_r && s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r      <= pos;
      s1_pix_r      <= in_data.pixel_color;
      s1_fwd_r      <= s1_wr && (s1_pos_r.landscape == pos.landscape) &&
                       (s1_pos_r.addr == pos.addr);
      s1_fwd_data_r <= shown;
    end
    if (s1_valid_r && s1_adv) begin
      out_data_r.pixel_x          <= s1_pos_r.x;
      out_data_r.pixel_y          <= s1_pos_r.y;
      out_data_r.shown_color      <= shown;
      out_data_r.background_color <= back;
      out_data_r.in_frame         <= s1_pos_r.in_bounds;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
